// ===== design/sledf_pkg.sv =====
package sledf_pkg;

    // Default for the compile-time ceiling on the frame byte count
    localparam int MAX_FRAME_DEF = 4096;

    // Field widths
    localparam int CNT_W = 13;
    localparam int LEN_W = 16;
    localparam int TICK_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Request codes
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_OK = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_FRAME = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW = 3'd2;
    localparam logic [2:0] ERR_TIMEOUT = 3'd3;
    localparam logic [2:0] ERR_CANCEL = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUNT_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE = 2'd3;

    // Configuration reset values
    localparam logic [CNT_W-1:0] MAX_FRAME_BYTES_RST = 13'd1024;
    localparam logic [TICK_W-1:0] HUNT_TIMEOUT_RST = 16'd3000;
    localparam logic [7:0] START_BYTE_RST = 8'd2;
    localparam logic [7:0] END_BYTE_RST = 8'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] frame_length;
        logic [2:0]       error_code;
    } out_item_t;

    // Settings seen by the frame engine
    typedef struct packed {
        logic [CNT_W-1:0]  limit;
        logic [TICK_W-1:0] hunt_timeout;
        logic [7:0]        start_byte;
        logic [7:0]        end_byte;
    } eng_cfg_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } eng_res_t;

endpackage

// ===== design/sledf_engine.sv =====
module sledf_engine
    import sledf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      go,
    input  in_item_t  item,
    input  eng_cfg_t  cfg,
    output eng_res_t  res
);

    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [7:0]        lrc_reg, lrc_next;
    logic              endok_reg, endok_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;

    logic [TICK_W-1:0] ticks_inc;
    logic [LEN_W:0]    idx_ext;
    logic [LEN_W:0]    len_ext;

    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
    assign idx_ext = {{(LEN_W + 1 - CNT_W){1'b0}}, count_reg};

    always_comb begin
        in_frame_next = in_frame_reg;
        count_next = count_reg;
        len_next = len_reg;
        lrc_next = lrc_reg;
        endok_next = endok_reg;
        ticks_next = ticks_reg;
        res = '0;
        len_ext = '0;

        if (!in_frame_reg) begin
            case (item.req_type)
                REQ_TICK: begin
                    if (ticks_inc >= cfg.hunt_timeout) begin
                        ticks_next = '0;
                        res.valid = 1'b1;
                        res.item.result_kind = KIND_ERR;
                        res.item.error_code = ERR_TIMEOUT;
                    end else begin
                        ticks_next = ticks_inc;
                    end
                end
                REQ_CANCEL: begin
                    ticks_next = '0;
                    res.valid = 1'b1;
                    res.item.result_kind = KIND_ERR;
                    res.item.error_code = ERR_CANCEL;
                end
                REQ_BYTE: begin
                    if (item.rx_byte == cfg.start_byte) begin
                        if (cfg.limit == '0) begin
                            ticks_next = '0;
                            res.valid = 1'b1;
                            res.item.result_kind = KIND_ERR;
                            res.item.error_code = ERR_OVERFLOW;
                        end else begin
                            in_frame_next = 1'b1;
                            count_next = CNT_W'(1);
                            len_next = '0;
                            lrc_next = '0;
                            endok_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end else if (item.req_type == REQ_BYTE) begin
            if (count_reg >= cfg.limit) begin
                // would exceed the byte limit
                in_frame_next = 1'b0;
                count_next = '0;
                len_next = '0;
                lrc_next = '0;
                endok_next = 1'b0;
                ticks_next = '0;
                res.valid = 1'b1;
                res.item.result_kind = KIND_ERR;
                res.item.error_code = ERR_OVERFLOW;
            end else begin
                count_next = count_reg + 1'b1;
                lrc_next = lrc_reg ^ item.rx_byte;
                if (count_reg == CNT_W'(1)) begin
                    len_next = {item.rx_byte, 8'h00};
                end else if (count_reg == CNT_W'(2)) begin
                    len_next = {len_reg[LEN_W-1:8], item.rx_byte};
                end
                len_ext = {1'b0, len_next};
                if (idx_ext == len_ext + 17'd2) begin
                    endok_next = (item.rx_byte == cfg.end_byte);
                end
                if (idx_ext == len_ext + 17'd3) begin
                    // last byte: check end marker and LRC, then hunt again
                    res.valid = 1'b1;
                    if (endok_next && lrc_next == 8'h00) begin
                        res.item.result_kind = KIND_OK;
                        res.item.frame_length = len_next;
                    end else begin
                        res.item.result_kind = KIND_ERR;
                        res.item.error_code = ERR_FRAME;
                    end
                    in_frame_next = 1'b0;
                    count_next = '0;
                    len_next = '0;
                    lrc_next = '0;
                    endok_next = 1'b0;
                    ticks_next = '0;
                end else if (count_reg >= CNT_W'(3) && idx_ext <= len_ext + 17'd1) begin
                    res.valid = 1'b1;
                    res.item.result_kind = KIND_PAYLOAD;
                    res.item.payload_byte = item.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg <= '0;
            len_reg <= '0;
            lrc_reg <= '0;
            endok_reg <= 1'b0;
            ticks_reg <= '0;
        end else if (go) begin
            in_frame_reg <= in_frame_next;
            count_reg <= count_next;
            len_reg <= len_next;
            lrc_reg <= lrc_next;
            endok_reg <= endok_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

// ===== design/stx_length_etx_lrc_deframer_core.sv =====
// A result reaches m_valid through the input register and then the output register, or the skid entry when stalled.
// Throughput: one transaction per cycle while the skid entry is empty; the frame engine steps once per transaction.
// The output register plus a one-entry skid buffer keep s_ready free of m_ready.
// Reset: synchronous, active low; clears the frame state, the valid flags and
// returns the configuration registers to their defaults.
module stx_length_etx_lrc_deframer_core
    import sledf_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input transactions
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    // result transactions
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Ceiling from the parameter, clipped to what the count register can hold
    localparam logic [CNT_W-1:0] MAX_CLIP =
        (MAX_FRAME < (2 ** CNT_W) - 1) ? CNT_W'(MAX_FRAME) : '1;

    // Configuration registers
    logic [CNT_W-1:0]  max_frame_reg;
    logic [TICK_W-1:0] hunt_timeout_reg;
    logic [7:0]        start_byte_reg;
    logic [7:0]        end_byte_reg;

    // Input stage
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;

    // Output register and skid entry
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t skid_item_reg, skid_item_next;

    logic      proc_go;
    logic      drain;
    logic      new_res;
    eng_cfg_t  eng_cfg;
    eng_res_t  eng_res;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_reg <= MAX_FRAME_BYTES_RST;
            hunt_timeout_reg <= HUNT_TIMEOUT_RST;
            start_byte_reg <= START_BYTE_RST;
            end_byte_reg <= END_BYTE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAX_FRAME:    max_frame_reg <= cfg_data[CNT_W-1:0];
                CFG_HUNT_TIMEOUT: hunt_timeout_reg <= cfg_data[TICK_W-1:0];
                CFG_START_BYTE:   start_byte_reg <= cfg_data[7:0];
                CFG_END_BYTE:     end_byte_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Effective limit is the smaller of the register and the ceiling
    assign eng_cfg.limit = (max_frame_reg > MAX_CLIP) ? MAX_CLIP : max_frame_reg;
    assign eng_cfg.hunt_timeout = hunt_timeout_reg;
    assign eng_cfg.start_byte = start_byte_reg;
    assign eng_cfg.end_byte = end_byte_reg;

    // Advance the held transaction whenever the skid entry is free; the
    // output side then always has room for one new result.
    assign proc_go = in_valid_reg && !skid_valid_reg;
    assign s_ready = !in_valid_reg || proc_go;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (proc_go) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    sledf_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (proc_go),
        .item    (in_item_reg),
        .cfg     (eng_cfg),
        .res     (eng_res)
    );

    assign drain = out_valid_reg && m_ready;
    assign new_res = proc_go && eng_res.valid;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_item_next = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next = skid_item_reg;
        // drain: move the skid entry up, or empty the output register
        if (drain) begin
            if (skid_valid_reg) begin
                out_item_next = skid_item_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        // land a new result in the output register, or park it in the skid entry
        if (new_res) begin
            if (!out_valid_reg || drain) begin
                out_valid_next = 1'b1;
                out_item_next = eng_res.item;
            end else begin
                skid_valid_next = 1'b1;
                skid_item_next = eng_res.item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_item_reg <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item = out_item_reg;

endmodule

// ===== design/sledf_checker.sv =====
module sledf_checker
    import sledf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // No result may be pending right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // Payload and accept results carry no error code
    a_no_err_on_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.result_kind == KIND_PAYLOAD || m_item.result_kind == KIND_OK)
        |-> m_item.error_code == ERR_NONE)
        else $error("error code on a good result");

    // Error results carry a real code and no data
    a_err_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.result_kind == KIND_ERR
        |-> m_item.error_code != ERR_NONE && m_item.payload_byte == 8'h00
            && m_item.frame_length == '0)
        else $error("malformed error result");

    // Only defined result kinds appear
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.result_kind == KIND_PAYLOAD || m_item.result_kind == KIND_OK
            || m_item.result_kind == KIND_ERR)
        else $error("undefined result kind");

endmodule

bind stx_length_etx_lrc_deframer_core sledf_checker u_sledf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
